[rtl/core/rptm_pkg.sv]
// Package: types and constants shared by the packed-text modexp block.
package rptm_pkg;

    localparam int WORD_W     = 31;
    localparam int CHAR_W     = 7;
    localparam int CNT_W      = 3;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam int MAX_CHARS  = 4;
    localparam int EXP_STEPS  = 31;

    // register indexes on the configuration port
    localparam logic [1:0] REG_DIRECTION = 2'd0;
    localparam logic [1:0] REG_EXPONENT  = 2'd1;
    localparam logic [1:0] REG_MODULUS   = 2'd2;
    localparam logic [1:0] REG_BLOCK     = 2'd3;

    // direction codes
    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0] in_value;
        logic              message_end;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] out_value;
        logic              last_of_run;
    } t_out_item;

endpackage

[rtl/core/rptm_mulmod.sv]
// Iterative modular multiplier: one bit of the multiplier per cycle, MSB first.
module rptm_mulmod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rptm_pkg::WORD_W-1:0] i_a,
    input  logic [rptm_pkg::WORD_W-1:0] i_b,
    input  logic [rptm_pkg::WORD_W-1:0] i_mod,
    output logic                       o_done,
    output logic [rptm_pkg::WORD_W-1:0] o_prod
);
    localparam int W = rptm_pkg::WORD_W;

    logic [W-1:0] r_a, n_a;
    logic [W-1:0] r_b;
    logic [W-1:0] r_p, n_p;
    logic [4:0]   r_cnt, n_cnt;
    logic         r_done, n_done;
    logic [W+1:0] w_t;
    logic [W+1:0] w_m1;
    logic [W+1:0] w_m2;
    logic [W+1:0] w_red;

    // double, add the selected multiplicand, fold back below the modulus
    always_comb begin
        w_m1 = {2'b00, i_mod};
        w_m2 = {1'b0, i_mod, 1'b0};
        w_t  = {1'b0, r_p, 1'b0} + (r_a[W-1] ? {2'b00, r_b} : {(W+2){1'b0}});
        if (w_t >= w_m2) begin
            w_red = w_t - w_m2;
        end else if (w_t >= w_m1) begin
            w_red = w_t - w_m1;
        end else begin
            w_red = w_t;
        end
    end

    // advance one multiplier bit per cycle
    always_comb begin
        n_a    = r_a;
        n_p    = r_p;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_a   = i_a;
            n_p   = '0;
            n_cnt = 5'(W);
        end else if (r_cnt != 5'd0) begin
            n_a    = {r_a[W-2:0], 1'b0};
            n_p    = w_red[W-1:0];
            n_cnt  = r_cnt - 5'd1;
            n_done = (r_cnt == 5'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_a <= n_a;
        r_p <= n_p;
        if (i_start) begin
            r_b <= i_b;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;
endmodule

[rtl/core/rptm_cell.sv]
// One character cell of the unpacking row: loads a slice, then passes it down.
module rptm_cell (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic                        i_shift,
    input  logic [rptm_pkg::CHAR_W-1:0] i_load_char,
    input  logic [rptm_pkg::CHAR_W-1:0] i_neighbor,
    output logic [rptm_pkg::CHAR_W-1:0] o_char
);
    logic [rptm_pkg::CHAR_W-1:0] r_char;

    // load from the product or take the upper neighbor's character
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_char <= i_load_char;
        end else if (i_shift) begin
            r_char <= i_neighbor;
        end
    end

    assign o_char = r_char;
endmodule

[rtl/core/rsa_packed_text_modexp_core.sv]
// Top level of the toy RSA packed-text modular exponentiation block.
// Encrypting, characters are packed 7 bits each, least significant first;
// a full block (or message_end) starts one exponentiation and yields one
// cipher word. Decrypting, each cipher word is exponentiated and returned as
// chars_per_block characters from a row of cells, the last one flagged.
// One exponentiation is a base reduction followed by 31 exponent-bit steps,
// each done by the bit-serial modular multipliers (square and multiply run
// side by side in each exponent step). Each further character is shown in
// the cycle after the previous one is taken. Items that only add a character
// are taken without starting an exponentiation. The block takes one item at
// a time.
module rsa_packed_text_modexp_core #(
    parameter int MAX_CHARS = rptm_pkg::MAX_CHARS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  rptm_pkg::t_in_item           i_data,
    output logic                         o_valid,
    input  logic                         i_ready,
    output rptm_pkg::t_out_item          o_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rptm_pkg::ADDR_W-1:0]  paddr,
    input  logic [rptm_pkg::DATA_W-1:0]  pwdata,
    output logic [rptm_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    localparam int W     = rptm_pkg::WORD_W;
    localparam int CW    = rptm_pkg::CHAR_W;
    localparam int NW    = rptm_pkg::CNT_W;
    localparam int ACC_W = CW * MAX_CHARS;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_REDUCE = 2'd1;
    localparam logic [1:0] S_EXP    = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic           r_dir;
    logic [W-1:0]   r_exp;
    logic [W-1:0]   r_mod;
    logic [NW-1:0]  r_cpb;
    logic [ACC_W-1:0] r_acc;
    logic [NW-1:0]  r_collected;
    logic [1:0]     r_state, n_state;
    logic [4:0]     r_k;
    logic [W-1:0]   r_res;
    logic [W-1:0]   r_sq;
    logic           r_job_dec;
    logic [NW-1:0]  r_left;

    logic           w_cfg_wr;
    logic [W-1:0]   w_mod_eff;
    logic [NW-1:0]  w_blk;
    logic           w_accept;
    logic           w_out_take;
    logic [ACC_W-1:0] w_acc_next;
    logic [NW-1:0]  w_cnt_next;
    logic           w_enc_emit;
    logic           w_start_a;
    logic           w_start_b;
    logic [W-1:0]   w_a_in;
    logic [W-1:0]   w_a_b;
    logic           w_done_a;
    logic           w_done_b;
    logic [W-1:0]   w_prod_a;
    logic [W-1:0]   w_prod_b;
    logic           w_exp_fin;
    logic           w_cell_load;
    logic           w_cell_shift;
    logic [CW-1:0]  w_chain [MAX_CHARS+1];

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= rptm_pkg::DIR_ENCRYPT;
            r_exp <= W'(1);
            r_mod <= {W{1'b1}};
            r_cpb <= NW'(1);
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                rptm_pkg::REG_DIRECTION: r_dir <= pwdata[0];
                rptm_pkg::REG_EXPONENT:  r_exp <= pwdata[W-1:0];
                rptm_pkg::REG_MODULUS:   r_mod <= pwdata[W-1:0];
                rptm_pkg::REG_BLOCK:     r_cpb <= pwdata[NW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            rptm_pkg::REG_DIRECTION: prdata = {31'd0, r_dir};
            rptm_pkg::REG_EXPONENT:  prdata = {1'b0, r_exp};
            rptm_pkg::REG_MODULUS:   prdata = {1'b0, r_mod};
            rptm_pkg::REG_BLOCK:     prdata = {29'd0, r_cpb};
            default:                 prdata = '0;
        endcase
    end

    // effective modulus and block size
    assign w_mod_eff = (r_mod < W'(2)) ? W'(2) : r_mod;
    always_comb begin
        if (r_cpb == '0) begin
            w_blk = NW'(1);
        end else if (r_cpb > NW'(MAX_CHARS)) begin
            w_blk = NW'(MAX_CHARS);
        end else begin
            w_blk = r_cpb;
        end
    end

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_take = o_valid && i_ready;

    // pack the new character into its slot
    always_comb begin
        w_acc_next = r_acc;
        for (int j = 0; j < MAX_CHARS; j++) begin
            if (r_collected == NW'(j)) begin
                w_acc_next[j*CW +: CW] = i_data.in_value[CW-1:0];
            end
        end
        w_cnt_next = r_collected + NW'(1);
        w_enc_emit = (w_cnt_next >= w_blk) || i_data.message_end;
    end

    // sequencer
    assign w_exp_fin = (r_state == S_EXP) && w_done_a && (r_k == 5'(W-1));

    always_comb begin
        n_state   = r_state;
        w_start_a = 1'b0;
        w_start_b = 1'b0;
        w_a_in    = r_res;
        w_a_b     = r_sq;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (r_dir == rptm_pkg::DIR_DECRYPT) begin
                        w_start_a = 1'b1;
                        w_a_in    = i_data.in_value;
                        w_a_b     = W'(1);
                        n_state   = S_REDUCE;
                    end else if (w_enc_emit) begin
                        w_start_a = 1'b1;
                        w_a_in    = W'(w_acc_next);
                        w_a_b     = W'(1);
                        n_state   = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                if (w_done_a) begin
                    w_start_a = 1'b1;
                    w_start_b = 1'b1;
                    w_a_in    = W'(1);
                    w_a_b     = w_prod_a;
                    n_state   = S_EXP;
                end
            end
            S_EXP: begin
                if (w_done_a) begin
                    if (r_k == 5'(W-1)) begin
                        n_state = S_EMIT;
                    end else begin
                        w_start_a = 1'b1;
                        w_start_b = 1'b1;
                        w_a_in    = r_exp[r_k] ? w_prod_a : r_res;
                        w_a_b     = w_prod_b;
                    end
                end
            end
            S_EMIT: begin
                if (w_out_take && (r_left == '0)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_collected <= '0;
            r_k         <= '0;
            r_left      <= '0;
            r_job_dec   <= 1'b0;
        end else begin
            r_state <= n_state;
            // store or clear the packing state
            if (w_accept && (r_dir == rptm_pkg::DIR_ENCRYPT)) begin
                if (w_enc_emit) begin
                    r_acc       <= '0;
                    r_collected <= '0;
                end else begin
                    r_acc       <= w_acc_next;
                    r_collected <= w_cnt_next;
                end
            end
            if (w_accept) begin
                r_job_dec <= (r_dir == rptm_pkg::DIR_DECRYPT);
                r_left    <= (r_dir == rptm_pkg::DIR_DECRYPT) ? (w_blk - NW'(1)) : '0;
            end else if (w_out_take && (r_left != '0)) begin
                r_left <= r_left - NW'(1);
            end
            if ((r_state == S_REDUCE) && w_done_a) begin
                r_k <= '0;
            end else if ((r_state == S_EXP) && w_done_a) begin
                r_k <= r_k + 5'd1;
            end
        end
        // result and square registers
        if ((r_state == S_REDUCE) && w_done_a) begin
            r_res <= W'(1);
            r_sq  <= w_prod_a;
        end else if ((r_state == S_EXP) && w_done_a) begin
            if (r_exp[r_k]) begin
                r_res <= w_prod_a;
            end
            r_sq <= w_prod_b;
        end
    end

    rptm_mulmod u_mul_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start_a),
        .i_a     (w_a_in),
        .i_b     (w_a_b),
        .i_mod   (w_mod_eff),
        .o_done  (w_done_a),
        .o_prod  (w_prod_a)
    );

    // square the value that the multiply unit takes in the same step
    rptm_mulmod u_mul_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start_b),
        .i_a     (w_a_b),
        .i_b     (w_a_b),
        .i_mod   (w_mod_eff),
        .o_done  (w_done_b),
        .o_prod  (w_prod_b)
    );

    // row of character cells for unpacking the decrypted word
    assign w_cell_load  = w_exp_fin;
    assign w_cell_shift = w_out_take && r_job_dec;
    assign w_chain[MAX_CHARS] = '0;

    for (genvar g = 0; g < MAX_CHARS; g++) begin : g_cell
        rptm_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (w_cell_load),
            .i_shift     (w_cell_shift),
            .i_load_char (r_exp[r_k] ? w_prod_a[g*CW +: CW] : r_res[g*CW +: CW]),
            .i_neighbor  (w_chain[g+1]),
            .o_char      (w_chain[g])
        );
    end

    // present the result item
    assign o_valid = (r_state == S_EMIT);
    always_comb begin
        if (r_job_dec) begin
            o_data.out_value = {{(W-CW){1'b0}}, w_chain[0]};
        end else begin
            o_data.out_value = r_res;
        end
        o_data.last_of_run = (r_left == '0);
    end

    // squaring unit finishes with the multiply unit
    logic w_unused;
    assign w_unused = w_done_b;
endmodule

[rtl/core/rptm_checker.sv]
// Port-level checker for the packed-text modexp block, bound to the top level.
module rptm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input rptm_pkg::t_in_item  i_data,
    input logic                o_valid,
    input logic                i_ready,
    input rptm_pkg::t_out_item o_data
);
    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result item changed while stalled");

    // one item at a time: never taking input while a result is shown
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input ready while result pending");

    // taking the last result of a run frees the input side
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_data.last_of_run |=> o_ready && !o_valid)
        else $error("block not idle after last result");

    // more results follow a result that is not last
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_data.last_of_run |=> o_valid)
        else $error("run ended early");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");
endmodule

bind rsa_packed_text_modexp_core rptm_checker u_rptm_checker (.*);

[tb/rsa_packed_text_modexp_core_test.sv]
// Self-checking testbench for the packed-text RSA modexp core.
module rsa_packed_text_modexp_core_test;
    import rptm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT   = 38;
    localparam int SETTLE_CYC = 1200;
    localparam int HOLD_CYC   = 4000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    t_in_item          i_data = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    t_out_item         o_data;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    rsa_packed_text_modexp_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow key registers and packing state
    logic        key_dir = DIR_ENCRYPT;
    logic [30:0] key_exp = 31'd1;
    logic [30:0] key_mod = 31'h7FFF_FFFF;
    logic [2:0]  key_blk = 3'd1;
    logic [27:0] pack_acc = '0;
    logic [2:0]  pack_cnt = '0;

    t_in_item    pending_items[$];
    t_out_item   expected_words[$];
    int          errors = 0;
    int          items_sent = 0;
    int          words_seen = 0;
    int          cycle_cnt = 0;
    bit          calm;

    // no idling on either side in this window
    assign calm = (cycle_cnt >= 40000) && (cycle_cnt < 70000);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    function automatic logic [30:0] pow_mod(logic [30:0] base, logic [30:0] expo,
                                            longint unsigned m);
        longint unsigned acc;
        longint unsigned sq;
        acc = 1 % m;
        sq  = base % m;
        for (int k = 0; k < EXP_STEPS; k++) begin
            if (expo[k]) acc = (acc * sq) % m;
            sq = (sq * sq) % m;
        end
        return acc[30:0];
    endfunction

    // work out the words one accepted item causes
    task automatic predict_item(t_in_item it);
        int              blk;
        longint unsigned m;
        logic [30:0]     plain;
        t_out_item       w;
        blk = (key_blk == 0) ? 1 : (key_blk > MAX_CHARS) ? MAX_CHARS : key_blk;
        m   = (key_mod < 2) ? 2 : key_mod;
        if (key_dir == DIR_ENCRYPT) begin
            if (pack_cnt < MAX_CHARS)
                pack_acc = pack_acc | (28'(it.in_value[6:0]) << (CHAR_W * pack_cnt));
            pack_cnt = pack_cnt + 3'd1;
            if (pack_cnt >= blk || it.message_end) begin
                w.out_value   = pow_mod({3'b0, pack_acc}, key_exp, m);
                w.last_of_run = 1'b1;
                expected_words.push_back(w);
                pack_acc = '0;
                pack_cnt = '0;
            end
        end else begin
            plain = pow_mod(it.in_value, key_exp, m);
            for (int j = 0; j < blk; j++) begin
                w.out_value   = 31'((plain >> (CHAR_W * j)) & 31'd127);
                w.last_of_run = (j + 1 == blk);
                expected_words.push_back(w);
            end
        end
    endtask

    // driver: offer queued items, predict on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_item(i_data);
                items_sent++;
            end
            if (!i_valid || o_ready) begin
                if (pending_items.size() > 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    i_data  <= pending_items.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare words, throttle ready, one long hold-off
    int  hold_left = 0;
    bit  held = 1'b0;
    always @(posedge i_clk) begin
        t_out_item w;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                words_seen++;
                if (expected_words.size() == 0) begin
                    $error("unexpected word out_value=%0d", o_data.out_value);
                    errors++;
                end else begin
                    w = expected_words.pop_front();
                    if (o_data.out_value !== w.out_value) begin
                        $error("out_value expected %0d actual %0d",
                               w.out_value, o_data.out_value);
                        errors++;
                    end
                    if (o_data.last_of_run !== w.last_of_run) begin
                        $error("last_of_run expected %0b actual %0b",
                               w.last_of_run, o_data.last_of_run);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (!held && words_seen >= 20) begin
                held = 1'b1;
                hold_left = HOLD_CYC;
                i_ready <= 1'b0;
            end else begin
                i_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    task automatic add_item(logic [30:0] v, logic e);
        t_in_item it;
        it.in_value    = v;
        it.message_end = e;
        pending_items.push_back(it);
    endtask

    // hold until every item is in and every word is out, then let it settle
    task automatic drain();
        while (pending_items.size() > 0 || i_valid || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic reg_write(logic [1:0] idx, logic [31:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DIRECTION: key_dir = v[0];
            REG_EXPONENT:  key_exp = v[30:0];
            REG_MODULUS:   key_mod = v[30:0];
            REG_BLOCK:     key_blk = v[2:0];
            default: ;
        endcase
    endtask

    task automatic set_key(logic d, logic [30:0] e, logic [30:0] m, logic [2:0] b);
        reg_write(REG_DIRECTION, {31'b0, d});
        reg_write(REG_EXPONENT, {1'b0, e});
        reg_write(REG_MODULUS, {1'b0, m});
        reg_write(REG_BLOCK, {29'b0, b});
    endtask

    initial begin
        logic [30:0] e;
        logic [30:0] m;
        logic        d;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset key: identity encrypt, one char per block, wide char too
        add_item(31'd0, 1'b0);
        add_item(31'd127, 1'b0);
        add_item(31'h7FFF_FFFF, 1'b0);
        add_item(31'd5, 1'b1);
        drain();

        // full and partial blocks of four
        set_key(DIR_ENCRYPT, 31'd3, 31'd1000003, 3'd4);
        add_item(31'd1, 1'b0);
        add_item(31'd2, 1'b0);
        add_item(31'd3, 1'b0);
        add_item(31'd4, 1'b0);
        add_item(31'd9, 1'b0);
        add_item(31'd10, 1'b1);
        add_item(31'd11, 1'b0);
        add_item(31'd12, 1'b0);
        drain();

        // lower the block size mid-block, then out-of-range sizes
        reg_write(REG_BLOCK, 32'd1);
        add_item(31'd13, 1'b0);
        drain();
        reg_write(REG_BLOCK, 32'd0);
        add_item(31'd77, 1'b1);
        drain();
        reg_write(REG_BLOCK, 32'd7);
        add_item(31'h55, 1'b0);
        add_item(31'h2A, 1'b0);
        add_item(31'h7F, 1'b0);
        add_item(31'h01, 1'b0);
        drain();

        // decrypt: zero exponent, max exponent and modulus, small moduli
        set_key(DIR_DECRYPT, 31'd0, 31'h7FFF_FFFF, 3'd4);
        add_item(31'd12345, 1'b1);
        drain();
        reg_write(REG_EXPONENT, 32'h7FFF_FFFF);
        add_item(31'h7FFF_FFFF, 1'b0);
        add_item(31'd0, 1'b1);
        drain();
        reg_write(REG_MODULUS, 32'd0);
        add_item(31'd5, 1'b0);
        drain();
        reg_write(REG_MODULUS, 32'd1);
        add_item(31'd6, 1'b0);
        drain();
        set_key(DIR_DECRYPT, 31'd7, 31'd2, 3'd2);
        add_item(31'd3, 1'b0);
        drain();

        // random keys, mostly well-formed block sizes
        for (int p = 0; p < 9; p++) begin
            d = $urandom_range(0, 1);
            case ($urandom_range(0, 5))
                0: e = 31'd0;
                1: e = 31'd1;
                2: e = 31'h7FFF_FFFF;
                default: e = 31'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0: m = 31'($urandom_range(0, 3));
                1: m = 31'h7FFF_FFFF;
                default: m = 31'($urandom) | 31'd2;
            endcase
            set_key(d, e, m,
                    ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7))
                                                : 3'($urandom_range(1, 4)));
            for (int k = 0; k < 8; k++)
                add_item(31'($urandom), $urandom_range(0, 4) == 0);
            drain();
        end

        if (expected_words.size() != 0) begin
            $error("%0d words never arrived", expected_words.size());
            errors++;
        end
        $display("Sent %0d items over fixed and random keys in both directions;",
                 items_sent);
        $display("checked %0d result words, %0d mismatches.", words_seen, errors);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[rsa_packed_text_modexp_core.f]
rtl/core/rptm_pkg.sv
rtl/core/rptm_mulmod.sv
rtl/core/rptm_cell.sv
rtl/core/rsa_packed_text_modexp_core.sv
rtl/core/rptm_checker.sv
tb/rsa_packed_text_modexp_core_test.sv
